// File: rtl/dxt_block_decoder_unit_assert.svh
// Assertion macros used by the top-level block decoder module.
`ifndef DXT_BLOCK_DECODER_UNIT_ASSERT_SVH
`define DXT_BLOCK_DECODER_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define DBD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define DBD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dbd_pkg.sv
// Types and constants shared by the block decoder modules.
`timescale 1ns / 1ps
package dbd_pkg;

    // Format register codes; the unused code decodes as DXT1
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    // Colour code that is transparent black in three-colour mode
    localparam logic [1:0] CODE_FAR = 2'd3;

    // Interpolation weights, out of 256
    localparam logic [7:0] W_MID  = 8'd85;
    localparam logic [7:0] W_FAR  = 8'd171;
    localparam logic [7:0] W_HALF = 8'd128;

    // Reciprocals for the alpha palette divisions by 7 and by 5
    localparam int unsigned RECIP_SHIFT = 14;
    localparam logic [11:0] RECIP7 = 12'd2341;
    localparam logic [11:0] RECIP5 = 12'd3277;

    localparam logic [3:0] LAST_TEXEL = 4'd15;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Everything the texel emitter needs for one block
    typedef struct packed {
        t_rgb [3:0]        color;
        logic [7:0][7:0]   apal;
        logic [15:0][1:0]  ccode;
        logic [15:0][2:0]  acode5;
        logic [15:0][3:0]  a4;
        logic              four;
        logic              is3;
        logic              is5;
    } t_tile;

endpackage

// File: rtl/dbd_if.sv
// Handshake channels of the block decoder: config, block input, texel output.
`timescale 1ns / 1ps
interface dbd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] format;

    modport source (output valid, output format, input ready);
    modport sink   (input valid, input format, output ready);
endinterface

interface dbd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;

    modport source (output valid, output block_low, output block_high, input ready);
    modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

interface dbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] texel_index;
    logic       last;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output texel_index, output last, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input texel_index, input last, output ready);
endinterface

// File: rtl/dxt_block_decoder_unit.sv
// DXT1/3/5 block decoder: 16-byte blocks in, sixteen RGBA8 texel words out.
// A block passes stages 1, 2 and 3, then the emitter's block and output registers, before its first texel word.
// Throughput: one texel word per cycle while o_texel.ready holds, sixteen words per block, set by the emitter.
// Palette lanes run 3 stages ahead, so the next block is taken during emission.
// Reset (synchronous, active low) empties all stages and sets format to DXT1.
`timescale 1ns / 1ps
`include "dxt_block_decoder_unit_assert.svh"
module dxt_block_decoder_unit
    import dbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dbd_cfg_if.sink    i_cfg,
    dbd_in_if.sink     i_blk,
    dbd_out_if.source  o_texel
);

    logic [1:0]  r_format;

    // Stage 1: block register
    logic        r_v1;
    logic [63:0] r_lo1;
    logic [63:0] r_hi1;
    logic [1:0]  r_fmt1;

    // Stage 2 and 3 side data, lanes hold their own sums
    logic        r_v2, r_v3;
    logic        r_four2, r_is3_2, r_is5_2;
    logic        r_four3, r_is3_3, r_is5_3;
    logic [31:0] r_ccode2, r_ccode3;
    logic [63:0] r_lo2, r_lo3;
    t_rgb        r_e0_2, r_e1_2, r_e0_3, r_e1_3;
    logic [7:0]  r_a0_2, r_a1_2, r_a0_3, r_a1_3;

    logic        take, adv1, adv2, load, load_ready;
    logic        is3, is5, four;
    logic [63:0] colour;
    logic [15:0] c0, c1;
    t_rgb        e0, e1;
    logic [7:0]  e0_ch [3];
    logic [7:0]  e1_ch [3];
    logic [7:0]  mid_ch [3];
    logic [7:0]  far_ch [3];
    logic [7:0]  apal_lane [6];
    t_tile       tile;

    // Config register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_DXT1;
        end else if (i_cfg.valid) begin
            r_format <= i_cfg.format;
        end
    end

    // Pipeline flow control
    assign load        = r_v3 && load_ready;
    assign adv2        = r_v2 && (!r_v3 || load);
    assign adv1        = r_v1 && (!r_v2 || adv2);
    assign i_blk.ready = !r_v1 || adv1;
    assign take        = i_blk.valid && i_blk.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= take || (r_v1 && !adv1);
            r_v2 <= adv1 || (r_v2 && !adv2);
            r_v3 <= adv2 || (r_v3 && !load);
        end
    end

    // Decode the registered block
    assign is3    = (r_fmt1 == FMT_DXT3);
    assign is5    = (r_fmt1 == FMT_DXT5);
    assign colour = (is3 || is5) ? r_hi1 : r_lo1;
    assign c0     = colour[15:0];
    assign c1     = colour[31:16];
    assign four   = is3 || is5 || (c0 > c1);
    assign e0     = '{r: {c0[15:11], 3'b0}, g: {c0[10:5], 2'b0}, b: {c0[4:0], 3'b0}};
    assign e1     = '{r: {c1[15:11], 3'b0}, g: {c1[10:5], 2'b0}, b: {c1[4:0], 3'b0}};

    assign e0_ch[0] = e0.r;
    assign e0_ch[1] = e0.g;
    assign e0_ch[2] = e0.b;
    assign e1_ch[0] = e1.r;
    assign e1_ch[1] = e1.g;
    assign e1_ch[2] = e1.b;

    // Advance payload through the stages
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_lo1  <= i_blk.block_low;
            r_hi1  <= i_blk.block_high;
            r_fmt1 <= r_format;
        end
        if (adv1) begin
            r_four2  <= four;
            r_is3_2  <= is3;
            r_is5_2  <= is5;
            r_ccode2 <= colour[63:32];
            r_lo2    <= r_lo1;
            r_e0_2   <= e0;
            r_e1_2   <= e1;
            r_a0_2   <= r_lo1[7:0];
            r_a1_2   <= r_lo1[15:8];
        end
        if (adv2) begin
            r_four3  <= r_four2;
            r_is3_3  <= r_is3_2;
            r_is5_3  <= r_is5_2;
            r_ccode3 <= r_ccode2;
            r_lo3    <= r_lo2;
            r_e0_3   <= r_e0_2;
            r_e1_3   <= r_e1_2;
            r_a0_3   <= r_a0_2;
            r_a1_3   <= r_a1_2;
        end
    end

    // Colour lanes, one per channel
    for (genvar ch = 0; ch < 3; ch++) begin : g_color
        dbd_color_lane u_lane (
            .i_clk  (i_clk),
            .i_adv1 (adv1),
            .i_adv2 (adv2),
            .i_e0   (e0_ch[ch]),
            .i_e1   (e1_ch[ch]),
            .i_four (four),
            .o_mid  (mid_ch[ch]),
            .o_far  (far_ch[ch])
        );
    end

    // Alpha lanes, one per interpolated DXT5 code
    for (genvar k = 0; k < 6; k++) begin : g_alpha
        dbd_alpha_lane u_lane (
            .i_clk   (i_clk),
            .i_adv1  (adv1),
            .i_adv2  (adv2),
            .i_code  (3'(k + 2)),
            .i_a0    (r_lo1[7:0]),
            .i_a1    (r_lo1[15:8]),
            .o_alpha (apal_lane[k])
        );
    end

    // Gather lane results into one block description
    always_comb begin
        tile.color[0] = r_e0_3;
        tile.color[1] = r_e1_3;
        tile.color[2] = '{r: mid_ch[0], g: mid_ch[1], b: mid_ch[2]};
        tile.color[3] = r_four3 ? t_rgb'{r: far_ch[0], g: far_ch[1], b: far_ch[2]} : '0;
        tile.apal[0]  = r_a0_3;
        tile.apal[1]  = r_a1_3;
        for (int k = 0; k < 6; k++) begin
            tile.apal[k + 2] = apal_lane[k];
        end
        tile.ccode  = r_ccode3;
        tile.acode5 = r_lo3[63:16];
        tile.a4     = r_lo3;
        tile.four   = r_four3;
        tile.is3    = r_is3_3;
        tile.is5    = r_is5_3;
    end

    dbd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_v3),
        .i_tile       (tile),
        .o_load_ready (load_ready),
        .o_texel      (o_texel)
    );

    // Checks
    `DBD_ASSERT_NXT(a_take_fills, i_clk, i_rst_n, i_blk.valid && i_blk.ready, r_v1, "accepted block lost at stage 1")
    `DBD_ASSERT_NXT(a_stage3_hold, i_clk, i_rst_n, r_v3 && !load, r_v3, "stage 3 block dropped before load")
    `DBD_ASSERT_NXT(a_texel_seq, i_clk, i_rst_n, o_texel.valid && o_texel.ready && !o_texel.last, o_texel.valid && (o_texel.texel_index == $past(o_texel.texel_index) + 4'd1), "texel sequence broken inside a block")

endmodule

// File: rtl/dbd_color_lane.sv
// One colour channel lane: the two interpolated palette entries.
`timescale 1ns / 1ps
module dbd_color_lane
    import dbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_adv1,
    input  logic       i_adv2,
    input  logic [7:0] i_e0,
    input  logic [7:0] i_e1,
    input  logic       i_four,
    output logic [7:0] o_mid,
    output logic [7:0] o_far
);

    logic [7:0]  w_mid;
    logic [15:0] n_mid;
    logic [15:0] n_far;
    logic [15:0] r_mid;
    logic [15:0] r_far;
    logic [7:0]  r_mid_q;
    logic [7:0]  r_far_q;

    // Weighted sums; three-colour mode takes the average for code 2
    assign w_mid = i_four ? W_MID : W_HALF;
    assign n_mid = {8'b0, i_e0} * {8'b0, 8'(8'd255 - w_mid)} + {8'b0, i_e1} * {8'b0, w_mid};
    assign n_far = {8'b0, i_e0} * {8'b0, 8'(8'd255 - W_FAR)} + {8'b0, i_e1} * {8'b0, W_FAR};

    always_ff @(posedge i_clk) begin
        if (i_adv1) begin
            r_mid <= n_mid;
            r_far <= n_far;
        end
        if (i_adv2) begin
            r_mid_q <= r_mid[15:8];
            r_far_q <= r_far[15:8];
        end
    end

    assign o_mid = r_mid_q;
    assign o_far = r_far_q;

endmodule

// File: rtl/dbd_alpha_lane.sv
// One DXT5 alpha palette lane: entry i_code of the eight, for codes 2 to 7.
`timescale 1ns / 1ps
module dbd_alpha_lane
    import dbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_adv1,
    input  logic       i_adv2,
    input  logic [2:0] i_code,
    input  logic [7:0] i_a0,
    input  logic [7:0] i_a1,
    output logic [7:0] o_alpha
);

    logic        n_seven;
    logic [2:0]  w_a;
    logic [2:0]  w_b;
    logic [10:0] n_sum;
    logic        r_seven;
    logic        r_zero;
    logic        r_full;
    logic [10:0] r_sum;
    logic [22:0] prod;
    logic [7:0]  quot;
    logic [7:0]  r_alpha;

    // Pick the weights of the eight- or six-entry palette
    assign n_seven = i_a0 > i_a1;
    assign w_a     = n_seven ? 3'(3'd0 - i_code) : 3'(3'd6 - i_code);
    assign w_b     = 3'(i_code - 3'd1);
    assign n_sum   = {8'b0, w_a} * {3'b0, i_a0} + {8'b0, w_b} * {3'b0, i_a1};

    // Divide by 7 or 5 through a reciprocal multiply
    assign prod = {12'b0, r_sum} * {11'b0, (r_seven ? RECIP7 : RECIP5)};
    assign quot = prod[RECIP_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (i_adv1) begin
            r_sum   <= n_sum;
            r_seven <= n_seven;
            r_zero  <= !n_seven && (i_code == 3'd6);
            r_full  <= !n_seven && (i_code == 3'd7);
        end
        if (i_adv2) begin
            priority if (r_zero) begin
                r_alpha <= 8'd0;
            end else if (r_full) begin
                r_alpha <= 8'd255;
            end else begin
                r_alpha <= quot;
            end
        end
    end

    assign o_alpha = r_alpha;

endmodule

// File: rtl/dbd_merge.sv
// Texel emitter: merges lane palettes and codes into sixteen RGBA texel words.
`timescale 1ns / 1ps
module dbd_merge
    import dbd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load_valid,
    input  t_tile        i_tile,
    output logic         o_load_ready,
    dbd_out_if.source    o_texel
);

    logic       r_busy;
    logic [3:0] r_cnt;
    t_tile      r_tile;
    logic       r_out_valid;
    t_rgb       r_rgb;
    logic [7:0] r_alpha;
    logic [3:0] r_index;
    logic       r_last;

    logic       fire;
    logic       load;
    logic [1:0] code;
    t_rgb       n_rgb;
    logic [7:0] n_alpha;

    // Emit a texel whenever the output register is free or draining
    assign fire         = r_busy && (!r_out_valid || o_texel.ready);
    assign o_load_ready = !r_busy || (fire && (r_cnt == LAST_TEXEL));
    assign load         = i_load_valid && o_load_ready;

    // Look up the current texel in the palettes
    assign code  = r_tile.ccode[r_cnt];
    assign n_rgb = r_tile.color[code];

    always_comb begin
        priority if (!r_tile.four && (code == CODE_FAR)) begin
            n_alpha = 8'd0;
        end else if (r_tile.is5) begin
            n_alpha = r_tile.apal[r_tile.acode5[r_cnt]];
        end else if (r_tile.is3) begin
            n_alpha = {r_tile.a4[r_cnt], r_tile.a4[r_cnt]};
        end else begin
            n_alpha = 8'd255;
        end
    end

    // Control: busy flag, texel counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (fire) begin
                r_busy <= (r_cnt != LAST_TEXEL);
                r_cnt  <= 4'(r_cnt + 4'd1);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_texel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the block, advance the output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tile <= i_tile;
        end
        if (fire) begin
            r_rgb   <= n_rgb;
            r_alpha <= n_alpha;
            r_index <= r_cnt;
            r_last  <= (r_cnt == LAST_TEXEL);
        end
    end

    assign o_texel.valid       = r_out_valid;
    assign o_texel.red         = r_rgb.r;
    assign o_texel.green       = r_rgb.g;
    assign o_texel.blue        = r_rgb.b;
    assign o_texel.alpha       = r_alpha;
    assign o_texel.texel_index = r_index;
    assign o_texel.last        = r_last;

endmodule
